>>> design/init_script_power_patcher_macros.svh
// Assertion macros for the init script power patcher, used by ispp_queue.
// No dependencies; the assertion bodies vanish when SYNTHESIS is defined.
`ifndef INIT_SCRIPT_POWER_PATCHER_MACROS_SVH
`define INIT_SCRIPT_POWER_PATCHER_MACROS_SVH
`ifndef SYNTHESIS
`define ISPP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ISPP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define ISPP_ASSERT(label, clk, rst, prop)
`define ISPP_ASSERT_IMP(label, clk, rst, ante, cons)
`endif
`endif

>>> design/ispp_pkg.sv
// Package for the init script power patcher: payload types, queue entry,
// command opcodes and power rule constants. No dependencies.
`timescale 1ns / 1ps

package ispp_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [15:0] OPC_VECTOR = 16'hFD82;
   localparam logic [15:0] OPC_CLASS2 = 16'hFD87;
   localparam logic [15:0] OPC_SLEEP  = 16'hFD0C;

   localparam logic [8:0] POS_PAYLOAD_FIRST = 9'd3;
   localparam logic [8:0] POS_VECTOR_FIRST  = 9'd5;
   localparam logic [8:0] POS_VECTOR_LAST   = 9'd19;
   localparam logic [8:0] POS_CLASS2_FIRST  = 9'd3;
   localparam logic [8:0] POS_CLASS2_LAST   = 9'd5;
   localparam logic [8:0] POS_SLEEP         = 9'd4;
   localparam logic [8:0] POS_VECTOR_BASE   = 9'd4;

   localparam logic signed [8:0] FLOOR_DB      = -9'sd35;
   localparam logic signed [8:0] GFSK_CEILING  = 9'sd12;
   localparam logic signed [8:0] OTHER_CEILING = 9'sd10;
   localparam logic signed [8:0] UNDER_DB      = 9'sd4;
   localparam int unsigned STEP_DB   = 5;
   localparam int unsigned RANGE_DB  = 30;
   localparam int unsigned MAX_STEPS = RANGE_DB / STEP_DB;
   localparam logic [3:0] TOP_LEVEL  = 4'd15;

   localparam int unsigned CSR_DATA_W  = 7;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_POWER = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLEEP     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLE       = 2'd2;

   typedef enum logic [1:0] {
      RULE_NONE,
      RULE_VECTOR,
      RULE_CLASS2,
      RULE_SLEEP
   } rule_type;

   typedef struct packed {
      logic [7:0] script_byte;
      logic       last_script_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_command;
      logic       was_patched;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [6:0] max_power_db;
      logic              sleep_enable;
      logic              ble_level_one;
   } csr_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_command;
      rule_type   rule;
      logic [3:0] rule_index;
      logic       kind_zero;
   } entry_type;

endpackage

>>> design/ispp_front.sv
// Front end of the power patcher: parses script bytes into commands and
// classifies each passed byte by rewrite rule. Depends on ispp_pkg.
`timescale 1ns / 1ps

module ispp_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  ispp_pkg::req_payload_type req_payload,
   input  logic                     queue_full,
   output logic                     push,
   output ispp_pkg::entry_type      push_entry
);

   typedef enum logic [2:0] {
      PH_TYPE,
      PH_OP_LO,
      PH_OP_HI,
      PH_LEN,
      PH_PAYLOAD
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [8:0]  pos_ff, pos_in;
   logic [7:0]  left_ff, left_in;
   logic [15:0] opcode_ff, opcode_in;
   logic        kind_zero_ff, kind_zero_in;
   logic        accept;
   logic [7:0]  b;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign b         = req_payload.script_byte;
   assign push      = accept && (phase_ff != PH_TYPE);

   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      left_in      = left_ff;
      opcode_in    = opcode_ff;
      kind_zero_in = kind_zero_ff;
      push_entry                = '0;
      push_entry.data_byte      = b;
      push_entry.rule           = ispp_pkg::RULE_NONE;
      push_entry.kind_zero      = kind_zero_ff;
      unique case (phase_ff)
         PH_TYPE: begin
            phase_in = PH_OP_LO;
            pos_in   = 9'd0;
         end
         PH_OP_LO: begin
            opcode_in = {8'd0, b};
            pos_in    = 9'd1;
            phase_in  = PH_OP_HI;
         end
         PH_OP_HI: begin
            opcode_in = {b, opcode_ff[7:0]};
            pos_in    = 9'd2;
            phase_in  = PH_LEN;
         end
         PH_LEN: begin
            left_in = b;
            pos_in  = 9'd3;
            if (b == 8'd0) begin
               push_entry.end_of_command = 1'b1;
               phase_in = PH_TYPE;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            if (pos_ff == ispp_pkg::POS_PAYLOAD_FIRST) begin
               kind_zero_in = (b == 8'd0);
            end
            push_entry.kind_zero = kind_zero_in;
            if (opcode_ff == ispp_pkg::OPC_VECTOR && pos_ff >= ispp_pkg::POS_VECTOR_FIRST &&
                pos_ff <= ispp_pkg::POS_VECTOR_LAST) begin
               push_entry.rule       = ispp_pkg::RULE_VECTOR;
               push_entry.rule_index = 4'(pos_ff - ispp_pkg::POS_VECTOR_BASE);
            end else if (opcode_ff == ispp_pkg::OPC_CLASS2 &&
                         pos_ff >= ispp_pkg::POS_CLASS2_FIRST &&
                         pos_ff <= ispp_pkg::POS_CLASS2_LAST) begin
               push_entry.rule       = ispp_pkg::RULE_CLASS2;
               push_entry.rule_index = 4'(pos_ff - ispp_pkg::POS_CLASS2_FIRST);
            end else if (opcode_ff == ispp_pkg::OPC_SLEEP && pos_ff == ispp_pkg::POS_SLEEP) begin
               push_entry.rule = ispp_pkg::RULE_SLEEP;
            end
            pos_in  = pos_ff + 9'd1;
            left_in = left_ff - 8'd1;
            if (left_ff == 8'd1) begin
               push_entry.end_of_command = 1'b1;
               phase_in = PH_TYPE;
            end
         end
         default: begin
            phase_in = PH_TYPE;
         end
      endcase
      if (req_payload.last_script_byte) begin
         phase_in = PH_TYPE;
         pos_in   = 9'd0;
         left_in  = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TYPE;
         pos_ff       <= 9'd0;
         left_ff      <= 8'd0;
         opcode_ff    <= 16'd0;
         kind_zero_ff <= 1'b1;
      end else if (accept) begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         left_ff      <= left_in;
         opcode_ff    <= opcode_in;
         kind_zero_ff <= kind_zero_in;
      end
   end

endmodule

>>> design/ispp_queue.sv
// Short queue between the parser and the rewrite stage of the power patcher.
// Depends on ispp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "init_script_power_patcher_macros.svh"

module ispp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ispp_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output ispp_pkg::entry_type head_entry
);

   ispp_pkg::entry_type entries_ff [ispp_pkg::QUEUE_DEPTH];
   logic [ispp_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [ispp_pkg::QUEUE_CNT_W-1:0] count_ff;

   localparam logic [ispp_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
      ispp_pkg::QUEUE_PTR_W'(ispp_pkg::QUEUE_DEPTH - 1);
   localparam logic [ispp_pkg::QUEUE_CNT_W-1:0] DEPTH_CNT =
      ispp_pkg::QUEUE_CNT_W'(ispp_pkg::QUEUE_DEPTH);

   assign full       = (count_ff == DEPTH_CNT);
   assign head_valid = (count_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   `ISPP_ASSERT_IMP(no_push_when_full, clock, reset, full, !push)
   `ISPP_ASSERT_IMP(no_pop_when_empty, clock, reset, !head_valid, !pop)
   `ISPP_ASSERT(count_in_range, clock, reset, count_ff <= DEPTH_CNT)
   `ISPP_ASSERT_IMP(push_fills_queue, clock, reset, push && !pop, ##1 head_valid)

endmodule

>>> design/ispp_back.sv
// Rewrite stage of the power patcher: computes the patched byte for the
// queue head and holds the result beat. Depends on ispp_pkg.
`timescale 1ns / 1ps

module ispp_back (
   input  logic                      clock,
   input  logic                      reset,
   input  ispp_pkg::csr_type         csr,
   input  logic                      head_valid,
   input  ispp_pkg::entry_type       head_entry,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output ispp_pkg::rsp_payload_type rsp_payload
);

   logic                      valid_ff;
   ispp_pkg::rsp_payload_type payload_ff, payload_in;
   logic                      kind0;
   logic signed [8:0]         ceiling, max_db, capped, v_step, v_level;
   logic [3:0]                steps, steps_capped;
   logic [8:0]                drop;
   logic [7:0]                vector_byte, class2_byte;

   assign rsp_valid   = valid_ff;
   assign rsp_payload = payload_ff;
   assign pop         = head_valid && (!valid_ff || rsp_ready);

   always_comb begin
      kind0   = (head_entry.rule == ispp_pkg::RULE_CLASS2) ? (head_entry.rule_index == 4'd0)
                                                           : head_entry.kind_zero;
      ceiling = kind0 ? ispp_pkg::GFSK_CEILING : ispp_pkg::OTHER_CEILING;
      max_db  = 9'(csr.max_power_db);
      capped  = (ceiling > max_db) ? max_db : ceiling;

      steps        = ispp_pkg::TOP_LEVEL - head_entry.rule_index;
      steps_capped = (steps > 4'(ispp_pkg::MAX_STEPS)) ? 4'(ispp_pkg::MAX_STEPS) : steps;
      drop         = 9'(steps_capped) * 9'(ispp_pkg::STEP_DB);
      v_step       = capped - $signed(drop);
      v_level      = v_step;
      if (steps_capped != 4'd0 && v_step < ispp_pkg::FLOOR_DB) begin
         v_level = ispp_pkg::FLOOR_DB;
      end
      if (head_entry.rule_index == 4'd1 && head_entry.kind_zero && csr.ble_level_one) begin
         v_level = capped;
      end
      vector_byte = {v_level[6:0], 1'b0};

      if (capped < ispp_pkg::UNDER_DB) begin
         class2_byte = 8'(ispp_pkg::TOP_LEVEL);
      end else if (capped < ispp_pkg::UNDER_DB + 9'(ispp_pkg::STEP_DB)) begin
         class2_byte = 8'(ispp_pkg::TOP_LEVEL) - 8'd1;
      end else begin
         class2_byte = 8'(ispp_pkg::TOP_LEVEL) - 8'd2;
      end

      payload_in.last_of_command = head_entry.end_of_command;
      payload_in.was_patched     = (head_entry.rule != ispp_pkg::RULE_NONE);
      unique case (head_entry.rule)
         ispp_pkg::RULE_VECTOR: payload_in.out_byte = vector_byte;
         ispp_pkg::RULE_CLASS2: payload_in.out_byte = class2_byte;
         ispp_pkg::RULE_SLEEP:  payload_in.out_byte = {7'd0, csr.sleep_enable};
         default:               payload_in.out_byte = head_entry.data_byte;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         payload_ff <= payload_in;
      end
   end

endmodule

>>> design/init_script_power_patcher.sv
// Init script power patcher: one script byte per beat in, one result beat per passed byte out.
// Throughput is one byte per cycle; input stalls only while the queue holds two bytes behind a held result.
// An accepted byte is written into the queue, then into the result register once that register is free
// or taken; its beat is offered from there. Packet-type bytes are taken and give no result beat.
// Reset is synchronous: parser, queue and result valid clear, CSR registers take their defaults.
// Depends on ispp_pkg, ispp_front, ispp_queue and ispp_back.
`timescale 1ns / 1ps

module init_script_power_patcher (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  ispp_pkg::req_payload_type           req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output ispp_pkg::rsp_payload_type           rsp_payload,
   input  logic                                csr_we,
   input  logic [ispp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ispp_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   ispp_pkg::csr_type   csr_ff;
   ispp_pkg::entry_type push_entry, head_entry;
   logic                push, pop, queue_full, head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.max_power_db  <= 7'sd13;
         csr_ff.sleep_enable  <= 1'b0;
         csr_ff.ble_level_one <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            ispp_pkg::CSR_MAX_POWER: csr_ff.max_power_db  <= $signed(csr_wdata);
            ispp_pkg::CSR_SLEEP:     csr_ff.sleep_enable  <= csr_wdata[0];
            ispp_pkg::CSR_BLE:       csr_ff.ble_level_one <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   ispp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push),
      .push_entry  (push_entry)
   );

   ispp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   ispp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr         (csr_ff),
      .head_valid  (head_valid),
      .head_entry  (head_entry),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> verif/tb.sv
// Self-checking testbench for the init script power patcher: drives script bytes,
// predicts each result beat or uses a pinned one, and checks it field by field
// across several settings. Depends on ispp_pkg and init_script_power_patcher.
`timescale 1ns / 1ps

module tb;

   localparam int HOLD_CYCLES    = 80;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_BEATS    = 165;

   typedef enum logic [2:0] {
      SCAN_TYPE,
      SCAN_OP_LO,
      SCAN_OP_HI,
      SCAN_LEN,
      SCAN_PAYLOAD
   } scan_phase_type;

   typedef struct {
      ispp_pkg::req_payload_type beat;
      bit                        pinned;
      ispp_pkg::rsp_payload_type want;
   } script_row_type;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_ready;
   ispp_pkg::req_payload_type            req_payload;
   logic                                 rsp_valid;
   logic                                 rsp_ready;
   ispp_pkg::rsp_payload_type            rsp_payload;
   logic                                 csr_we;
   logic [ispp_pkg::CSR_INDEX_W-1:0]     csr_index;
   logic [ispp_pkg::CSR_DATA_W-1:0]      csr_wdata;

   bit                        pinned_valid;
   ispp_pkg::rsp_payload_type pinned_rsp;
   bit                        no_idle;
   bit                        backlog_hold;
   int                        mismatch_count;
   int                        quiet_cycles;

   script_row_type            pending_rows[$];
   ispp_pkg::rsp_payload_type pending_results[$];

   scan_phase_type    scan_phase;
   logic [8:0]        scan_pos;
   logic [7:0]        bytes_left;
   logic [15:0]       cmd_opcode;
   logic [7:0]        mod_kind;
   logic signed [6:0] cfg_max_power;
   logic              cfg_sleep;
   logic              cfg_ble;

   init_script_power_patcher dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int ceiling_db(input logic [7:0] kind);
      int p;
      int top;
      top = int'(cfg_max_power);
      p = (kind == 8'd0) ? 12 : 10;
      if (p > top)
         p = top;
      return p;
   endfunction

   function automatic logic [7:0] vector_level_value(input int lvl);
      int p;
      int k;
      int v;
      p = ceiling_db(mod_kind);
      if (lvl == 1 && mod_kind == 8'd0 && cfg_ble)
         return 8'(2 * p);
      k = 15 - lvl;
      if (k > 6)
         k = 6;
      v = p;
      if (k > 0) begin
         v = p - 5 * k;
         if (v < -35)
            v = -35;
      end
      return 8'(2 * v);
   endfunction

   function automatic logic [7:0] class2_level(input logic [7:0] kind);
      int p;
      int lvl;
      p = ceiling_db(kind);
      lvl = 15;
      while (lvl > 0 && p >= 4) begin
         p = p - 5;
         lvl = lvl - 1;
      end
      return 8'(lvl);
   endfunction

   function automatic bit predict_beat(input ispp_pkg::req_payload_type beat,
                                       output ispp_pkg::rsp_payload_type res);
      bit emits;
      logic [8:0] pos;
      emits = 1'b1;
      res.out_byte = beat.script_byte;
      res.last_of_command = 1'b0;
      res.was_patched = 1'b0;
      case (scan_phase)
         SCAN_OP_LO: begin
            cmd_opcode = {8'h00, beat.script_byte};
            scan_pos = 9'd1;
            scan_phase = SCAN_OP_HI;
         end
         SCAN_OP_HI: begin
            cmd_opcode[15:8] = beat.script_byte;
            scan_pos = 9'd2;
            scan_phase = SCAN_LEN;
         end
         SCAN_LEN: begin
            bytes_left = beat.script_byte;
            scan_pos = 9'd3;
            if (beat.script_byte == 8'd0) begin
               res.last_of_command = 1'b1;
               scan_phase = SCAN_TYPE;
            end else begin
               scan_phase = SCAN_PAYLOAD;
            end
         end
         SCAN_PAYLOAD: begin
            pos = scan_pos;
            if (pos == 9'd3)
               mod_kind = beat.script_byte;
            if (cmd_opcode == ispp_pkg::OPC_VECTOR && pos >= 9'd5 && pos <= 9'd19) begin
               res.out_byte = vector_level_value(int'(pos) - 4);
               res.was_patched = 1'b1;
            end else if (cmd_opcode == ispp_pkg::OPC_CLASS2 && pos >= 9'd3 && pos <= 9'd5) begin
               res.out_byte = class2_level(8'(pos - 9'd3));
               res.was_patched = 1'b1;
            end else if (cmd_opcode == ispp_pkg::OPC_SLEEP && pos == 9'd4) begin
               res.out_byte = {7'd0, cfg_sleep};
               res.was_patched = 1'b1;
            end
            scan_pos = pos + 9'd1;
            bytes_left = bytes_left - 8'd1;
            if (bytes_left == 8'd0) begin
               res.last_of_command = 1'b1;
               scan_phase = SCAN_TYPE;
            end
         end
         default: begin
            scan_phase = SCAN_OP_LO;
            scan_pos = 9'd0;
            emits = 1'b0;
         end
      endcase
      if (beat.last_script_byte) begin
         scan_phase = SCAN_TYPE;
         scan_pos = 9'd0;
         bytes_left = 8'd0;
      end
      return emits;
   endfunction

   always @(posedge clock) begin : monitor
      ispp_pkg::rsp_payload_type predicted;
      ispp_pkg::rsp_payload_type want;
      ispp_pkg::rsp_payload_type seen;
      if (reset) begin
         scan_phase = SCAN_TYPE;
         scan_pos = 9'd0;
         bytes_left = 8'd0;
         cmd_opcode = 16'd0;
         mod_kind = 8'd0;
         cfg_max_power = 7'sd13;
         cfg_sleep = 1'b0;
         cfg_ble = 1'b0;
         pending_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               ispp_pkg::CSR_MAX_POWER: cfg_max_power = csr_wdata;
               ispp_pkg::CSR_SLEEP:     cfg_sleep = csr_wdata[0];
               ispp_pkg::CSR_BLE:       cfg_ble = csr_wdata[0];
               default:                 ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (predict_beat(req_payload, predicted))
               pending_results.push_back(pinned_valid ? pinned_rsp : predicted);
         end
         if (rsp_valid && rsp_ready) begin
            seen = rsp_payload;
            if (pending_results.size() == 0) begin
               $display("%0t: result beat with none expected, actual %h", $time, seen);
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               if (seen.out_byte !== want.out_byte) begin
                  $display("%0t: out_byte expected %h actual %h",
                           $time, want.out_byte, seen.out_byte);
                  mismatch_count++;
               end
               if (seen.last_of_command !== want.last_of_command) begin
                  $display("%0t: last_of_command expected %b actual %b",
                           $time, want.last_of_command, seen.last_of_command);
                  mismatch_count++;
               end
               if (seen.was_patched !== want.was_patched) begin
                  $display("%0t: was_patched expected %b actual %b",
                           $time, want.was_patched, seen.was_patched);
                  mismatch_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (backlog_hold) begin
            rsp_ready <= 1'b0;
            for (int n = 1; n < HOLD_CYCLES; n++)
               @(negedge clock);
            backlog_hold = 1'b0;
         end else begin
            rsp_ready <= no_idle || ($urandom_range(0, 99) >= 11);
         end
      end
   end

   task automatic push_row(input logic [7:0] b, input bit last, input bit pin,
                           input logic [7:0] want_b, input bit want_end, input bit want_patch);
      script_row_type row;
      row.beat.script_byte = b;
      row.beat.last_script_byte = last;
      row.pinned = pin;
      row.want.out_byte = want_b;
      row.want.last_of_command = want_end;
      row.want.was_patched = want_patch;
      pending_rows.push_back(row);
   endtask

   task automatic queue_random_command(input bit script_end);
      logic [15:0] opc;
      logic [7:0]  body[$];
      int          sel;
      int          len;
      int          cut;
      sel = $urandom_range(0, 99);
      if (sel < 35)
         opc = ispp_pkg::OPC_VECTOR;
      else if (sel < 55)
         opc = ispp_pkg::OPC_CLASS2;
      else if (sel < 72)
         opc = ispp_pkg::OPC_SLEEP;
      else if (sel < 82)
         opc = ispp_pkg::OPC_VECTOR ^ (16'd1 << $urandom_range(0, 15));
      else
         opc = 16'($urandom);
      if ($urandom_range(0, 99) == 0)
         len = $urandom_range(21, 255);
      else if (opc == ispp_pkg::OPC_VECTOR && $urandom_range(0, 99) < 60)
         len = 17;
      else
         len = $urandom_range(0, 20);
      body.push_back(8'($urandom));
      body.push_back(opc[7:0]);
      body.push_back(opc[15:8]);
      body.push_back(8'(len));
      for (int i = 0; i < len; i++) begin
         if (i == 0 && $urandom_range(0, 4) != 0)
            body.push_back(8'($urandom_range(0, 3)));
         else
            body.push_back(8'($urandom));
      end
      cut = body.size() - 1;
      if (script_end && $urandom_range(0, 3) == 0)
         cut = $urandom_range(0, body.size() - 1);
      for (int i = 0; i <= cut; i++)
         push_row(body[i], script_end && i == cut, 1'b0, 8'd0, 1'b0, 1'b0);
   endtask

   task automatic fill_random_scripts(input int target);
      int cmds;
      while (pending_rows.size() < target) begin
         cmds = $urandom_range(1, 5);
         for (int i = 0; i < cmds; i++) begin
            if ($urandom_range(0, 99) < 5) begin
               for (int k = 0; k < $urandom_range(1, 3); k++)
                  push_row(8'($urandom), $urandom_range(0, 3) == 0, 1'b0, 8'd0, 1'b0, 1'b0);
            end
            queue_random_command(i == cmds - 1);
         end
      end
   endtask

   task automatic send_rows();
      script_row_type row;
      while (pending_rows.size() != 0) begin
         row = pending_rows.pop_front();
         while (!no_idle && $urandom_range(0, 99) < 11) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
         req_valid <= 1'b1;
         req_payload <= row.beat;
         pinned_valid <= row.pinned;
         pinned_rsp <= row.want;
         do
            @(posedge clock);
         while (!req_ready);
         @(negedge clock);
      end
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      pinned_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_power_config(input int max_db, input bit sleep_on, input bit ble_on);
      csr_we <= 1'b1;
      csr_index <= ispp_pkg::CSR_MAX_POWER;
      csr_wdata <= 7'(max_db);
      @(negedge clock);
      csr_index <= ispp_pkg::CSR_SLEEP;
      csr_wdata <= {6'd0, sleep_on};
      @(negedge clock);
      csr_index <= ispp_pkg::CSR_BLE;
      csr_wdata <= {6'd0, ble_on};
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_we = 1'b0;
      csr_index = ispp_pkg::CSR_MAX_POWER;
      csr_wdata = '0;
      pinned_valid = 1'b0;
      pinned_rsp = '0;
      no_idle = 1'b0;
      backlog_hold = 1'b0;
      mismatch_count = 0;
      quiet_cycles = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Short power vector on GFSK, then the class 2 command at reset settings.
      push_row(8'h01, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
      push_row(8'h82, 1'b0, 1'b1, 8'h82, 1'b0, 1'b0);
      push_row(8'hFD, 1'b0, 1'b1, 8'hFD, 1'b0, 1'b0);
      push_row(8'h04, 1'b0, 1'b1, 8'h04, 1'b0, 1'b0);
      push_row(8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0);
      push_row(8'h7F, 1'b0, 1'b1, 8'h7F, 1'b0, 1'b0);
      push_row(8'hAA, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
      push_row(8'h55, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
      push_row(8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
      push_row(8'h87, 1'b0, 1'b1, 8'h87, 1'b0, 1'b0);
      push_row(8'hFD, 1'b0, 1'b1, 8'hFD, 1'b0, 1'b0);
      push_row(8'h03, 1'b0, 1'b1, 8'h03, 1'b0, 1'b0);
      push_row(8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
      push_row(8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
      push_row(8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
      // A command with no payload ends on its length byte.
      push_row(8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
      push_row(8'h0C, 1'b0, 1'b1, 8'h0C, 1'b0, 1'b0);
      push_row(8'hFD, 1'b0, 1'b1, 8'hFD, 1'b0, 1'b0);
      push_row(8'h00, 1'b0, 1'b1, 8'h00, 1'b1, 1'b0);
      // Sleep command cut short by the end of the script on its patched byte.
      push_row(8'h04, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
      push_row(8'h0C, 1'b0, 1'b1, 8'h0C, 1'b0, 1'b0);
      push_row(8'hFD, 1'b0, 1'b1, 8'hFD, 1'b0, 1'b0);
      push_row(8'h05, 1'b0, 1'b1, 8'h05, 1'b0, 1'b0);
      push_row(8'hFF, 1'b0, 1'b1, 8'hFF, 1'b0, 1'b0);
      push_row(8'hFF, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1);

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: ;
            1: write_power_config(20, 1'b1, 1'b1);
            2: write_power_config(-60, 1'b0, 1'b1);
            3: write_power_config(-35, 1'b1, 1'b0);
            4: write_power_config(0, 1'b1, 1'b0);
            5: write_power_config(4, 1'b0, 1'b1);
            default: write_power_config(int'($urandom_range(0, 80)) - 60,
                                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         endcase
         no_idle = (ph == 2);
         if (ph == 3)
            backlog_hold = 1'b1;
         fill_random_scripts(pending_rows.size() + PHASE_BEATS);
         send_rows();
         settle_block();
      end

      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
